// File: sv/pic_pkg.sv
// shared types, constants and helpers for the pi controller
`timescale 1ns / 1ps

package pic_pkg;

   localparam int SIG_W       = 32;
   localparam int GAIN_W      = 24;
   localparam int PERIOD_W    = 24;
   localparam int PERIOD_FRAC = 24;
   localparam int MUL_A_W     = GAIN_W + 1;
   localparam int MUL_B_W     = SIG_W + 1;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;
   localparam int RND_W       = PROD_W + 1;
   localparam int SUM_W       = RND_W + 2;
   localparam int STEP_W      = 4;
   localparam int CSR_IDX_W   = 3;
   localparam int REQ_DATA_W  = 3 * SIG_W;

   localparam logic [CSR_IDX_W-1:0] REG_KP  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KI  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KAW = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LO  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_HI  = 3'd5;

   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_PRESET = 4'd14;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ROUND_G,
      OP_P_SAT,
      OP_KITS,
      OP_ADD_INTEG,
      OP_ADD_FF,
      OP_CLAMP,
      OP_DIFF,
      OP_SUM_LOAD,
      OP_EMIT,
      OP_SUM_ADD,
      OP_INTEG_SAT,
      OP_PRESET
   } op_type;

   typedef enum logic [1:0] {
      MA_KP,
      MA_KI,
      MA_KITS,
      MA_KAW
   } mul_a_type;

   typedef enum logic [1:0] {
      MB_ERR,
      MB_TS,
      MB_DIFF
   } mul_b_type;

   typedef enum logic {
      COND_NONE,
      COND_PRESET
   } cond_type;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   typedef struct packed {
      op_type    op;
      logic      mul_en;
      mul_a_type mul_a;
      mul_b_type mul_b;
      cond_type  cond;
      step_type  target;
      logic      wait_out;
      logic      last;
   } ctrl_word_type;

   typedef struct packed {
      ctrl_word_type cw;
      logic          exec;
      logic          load;
   } dp_ctrl_type;

   typedef struct packed {
      logic is_preset;
      logic out_free;
   } dp_status_type;

   function automatic logic signed [SIG_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
      if (v[SUM_W-1:SIG_W-1] == '0 || v[SUM_W-1:SIG_W-1] == '1) begin
         return v[SIG_W-1:0];
      end else if (v[SUM_W-1]) begin
         return {1'b1, {(SIG_W-1){1'b0}}};
      end else begin
         return {1'b0, {(SIG_W-1){1'b1}}};
      end
   endfunction

endpackage

// File: sv/pi_controller_backcalc_antiwindup.sv
// top level of the microcoded pi controller with back-calculation anti-windup
//
//  channel  direction  handshake             payload
//  req      in         req_tvalid/tready     tuser: command; tdata: error, feedforward, preset
//  rsp      out        rsp_tvalid/tready     tuser: saturated; tdata: drive_value
//  csr      in         csr_valid/csr_ready   csr_index, csr_data
//
//  a step item runs a 14-step microprogram on one shared 25x33 multiplier:
//  req_tready stays low from acceptance until the last step, and a preset jumps from step 0 to step 14;
//  the emit step holds while an earlier result is still waiting on rsp
//  reset (synchronous) clears the integrator, sets the register reset values
//  and empties the result register; csr_ready is always high
`timescale 1ns / 1ps

module pi_controller_backcalc_antiwindup
   import pic_pkg::*;
#(
   parameter int GAIN_FRACTION_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // error_value, feedforward_value, preset_value
   input  logic [0:0]            req_tuser,  // command
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [SIG_W-1:0]      rsp_tdata,  // drive_value
   output logic [0:0]            rsp_tuser,  // saturated
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [SIG_W-1:0]      csr_data
);

   step_type      step;
   ctrl_word_type cw;
   dp_ctrl_type   ctrl;
   dp_status_type status;
   logic          rsp_sat;

   assign csr_ready    = 1'b1;
   assign rsp_tuser[0] = rsp_sat;

   pic_ucode_rom u_rom (
      .step (step),
      .cw   (cw)
   );

   pic_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .status    (status),
      .cw        (cw),
      .step      (step),
      .req_ready (req_tready),
      .ctrl      (ctrl)
   );

   pic_datapath #(
      .GAIN_FRAC_BITS (GAIN_FRACTION_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .status          (status),
      .req_command     (req_tuser[0]),
      .req_error       (req_tdata[SIG_W-1:0]),
      .req_feedforward (req_tdata[2*SIG_W-1:SIG_W]),
      .req_preset      (req_tdata[3*SIG_W-1:2*SIG_W]),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_drive       (rsp_tdata),
      .rsp_sat         (rsp_sat)
   );

endmodule

// File: sv/pic_ucode_rom.sv
// microcode table: one control word per program step
`timescale 1ns / 1ps

module pic_ucode_rom
   import pic_pkg::*;
(
   input  step_type      step,
   output ctrl_word_type cw
);

   always_comb begin
      cw = '0;
      unique case (step)
         4'd0: begin
            cw.mul_en = 1'b1;
            cw.mul_a  = MA_KP;
            cw.mul_b  = MB_ERR;
            cw.cond   = COND_PRESET;
            cw.target = STEP_PRESET;
         end
         4'd1: begin
            cw.op     = OP_ROUND_G;
            cw.mul_en = 1'b1;
            cw.mul_a  = MA_KI;
            cw.mul_b  = MB_TS;
         end
         4'd2: cw.op = OP_P_SAT;
         4'd3: cw.op = OP_KITS;
         4'd4: begin
            cw.op     = OP_ADD_INTEG;
            cw.mul_en = 1'b1;
            cw.mul_a  = MA_KITS;
            cw.mul_b  = MB_ERR;
         end
         4'd5: cw.op = OP_ADD_FF;
         4'd6: cw.op = OP_ROUND_G;
         4'd7: cw.op = OP_CLAMP;
         4'd8: cw.op = OP_DIFF;
         4'd9: begin
            cw.op     = OP_SUM_LOAD;
            cw.mul_en = 1'b1;
            cw.mul_a  = MA_KAW;
            cw.mul_b  = MB_DIFF;
         end
         4'd10: begin
            cw.op       = OP_EMIT;
            cw.wait_out = 1'b1;
         end
         4'd11: cw.op = OP_ROUND_G;
         4'd12: cw.op = OP_SUM_ADD;
         4'd13: begin
            cw.op   = OP_INTEG_SAT;
            cw.last = 1'b1;
         end
         4'd14: begin
            cw.op   = OP_PRESET;
            cw.last = 1'b1;
         end
         default: cw = '0;
      endcase
   end

endmodule

// File: sv/pic_sequencer.sv
// step counter with conditional jump and output-wait stall
`timescale 1ns / 1ps

module pic_sequencer
   import pic_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  dp_status_type status,
   input  ctrl_word_type cw,
   output step_type      step,
   output logic          req_ready,
   output dp_ctrl_type   ctrl
);

   seq_state_type state_ff, state_in;
   step_type      step_ff, step_in;
   logic          stall;

   assign stall = cw.wait_out && !status.out_free;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (req_valid) begin
               state_in = SEQ_RUN;
               step_in  = '0;
            end
         end
         SEQ_RUN: begin
            if (!stall) begin
               if (cw.last) begin
                  state_in = SEQ_IDLE;
               end
               if (cw.cond == COND_PRESET && status.is_preset) begin
                  step_in = cw.target;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   always_comb begin
      step      = step_ff;
      req_ready = (state_ff == SEQ_IDLE);
      ctrl.cw   = cw;
      ctrl.exec = (state_ff == SEQ_RUN) && !stall;
      ctrl.load = (state_ff == SEQ_IDLE) && req_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// File: sv/pic_datapath.sv
// registers, shared multiplier, rounding, saturation and output register
`timescale 1ns / 1ps

module pic_datapath
   import pic_pkg::*;
#(
   parameter int GAIN_FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  dp_ctrl_type                 ctrl,
   output dp_status_type               status,
   input  logic                        req_command,
   input  logic signed [SIG_W-1:0]     req_error,
   input  logic signed [SIG_W-1:0]     req_feedforward,
   input  logic signed [SIG_W-1:0]     req_preset,
   input  logic                        csr_valid,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [SIG_W-1:0]            csr_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [SIG_W-1:0]            rsp_drive,
   output logic                        rsp_sat
);

   localparam logic signed [RND_W-1:0] HALF_G =
      {{(RND_W-1){1'b0}}, 1'b1} << (GAIN_FRAC_BITS - 1);
   localparam logic signed [RND_W-1:0] HALF_T =
      {{(RND_W-1){1'b0}}, 1'b1} << (PERIOD_FRAC - 1);

   logic signed [GAIN_W-1:0]   kp_ff, ki_ff, kaw_ff;
   logic        [PERIOD_W-1:0] ts_ff;
   logic signed [SIG_W-1:0]    lo_ff, hi_ff;

   logic                       cmd_ff;
   logic signed [SIG_W-1:0]    err_ff, ffw_ff, pre_ff;

   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [RND_W-1:0]    rnd_ff;
   logic signed [SIG_W-1:0]    unc_ff, clamp_ff, integ_ff;
   logic                       sat_ff;
   logic signed [MUL_A_W-1:0]  kits_ff;
   logic signed [MUL_B_W-1:0]  diff_ff;
   logic signed [SUM_W-1:0]    sum_ff;

   logic                       out_valid_ff, out_sat_ff;
   logic        [SIG_W-1:0]    out_drive_ff;

   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [RND_W-1:0]    prod_ext, rnd_g, rnd_t;
   logic signed [SIG_W-1:0]    clamp_v;
   logic                       sat_v;
   logic                       do_op;

   assign do_op = ctrl.exec;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff  <= '0;
         ki_ff  <= '0;
         ts_ff  <= '0;
         kaw_ff <= '0;
         lo_ff  <= {1'b1, {(SIG_W-1){1'b0}}};
         hi_ff  <= {1'b0, {(SIG_W-1){1'b1}}};
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_KP:  kp_ff  <= csr_data[GAIN_W-1:0];
            REG_KI:  ki_ff  <= csr_data[GAIN_W-1:0];
            REG_TS:  ts_ff  <= csr_data[PERIOD_W-1:0];
            REG_KAW: kaw_ff <= csr_data[GAIN_W-1:0];
            REG_LO:  lo_ff  <= csr_data;
            REG_HI:  hi_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (ctrl.cw.mul_a)
         MA_KP:   mul_a = MUL_A_W'(kp_ff);
         MA_KI:   mul_a = MUL_A_W'(ki_ff);
         MA_KITS: mul_a = kits_ff;
         MA_KAW:  mul_a = MUL_A_W'(kaw_ff);
      endcase
   end

   always_comb begin
      unique case (ctrl.cw.mul_b)
         MB_ERR:  mul_b = MUL_B_W'(err_ff);
         MB_TS:   mul_b = MUL_B_W'(ts_ff);
         MB_DIFF: mul_b = diff_ff;
         default: mul_b = '0;
      endcase
   end

   always_comb begin
      prod_ext = RND_W'(prod_ff);
      rnd_g    = (prod_ext + HALF_G) >>> GAIN_FRAC_BITS;
      rnd_t    = (prod_ext + HALF_T) >>> PERIOD_FRAC;
   end

   // limits may cross: the lower one wins
   always_comb begin
      priority if (unc_ff < lo_ff) begin
         clamp_v = lo_ff;
         sat_v   = 1'b1;
      end else if (unc_ff > hi_ff) begin
         clamp_v = hi_ff;
         sat_v   = 1'b1;
      end else begin
         clamp_v = unc_ff;
         sat_v   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cmd_ff <= req_command;
         err_ff <= req_error;
         ffw_ff <= req_feedforward;
         pre_ff <= req_preset;
      end
      if (do_op && ctrl.cw.mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      if (do_op) begin
         unique case (ctrl.cw.op)
            OP_ROUND_G:   rnd_ff   <= rnd_g;
            OP_P_SAT:     unc_ff   <= sat32(SUM_W'(rnd_ff));
            OP_KITS:      kits_ff  <= rnd_t[MUL_A_W-1:0];
            OP_ADD_INTEG: unc_ff   <= sat32(SUM_W'(unc_ff) + SUM_W'(integ_ff));
            OP_ADD_FF:    unc_ff   <= sat32(SUM_W'(unc_ff) + SUM_W'(ffw_ff));
            OP_CLAMP: begin
               clamp_ff <= clamp_v;
               sat_ff   <= sat_v;
            end
            OP_DIFF:      diff_ff  <= MUL_B_W'(clamp_ff) - MUL_B_W'(unc_ff);
            OP_SUM_LOAD:  sum_ff   <= SUM_W'(rnd_ff) + SUM_W'(integ_ff);
            OP_SUM_ADD:   sum_ff   <= sum_ff + SUM_W'(rnd_ff);
            OP_EMIT: begin
               out_drive_ff <= clamp_ff;
               out_sat_ff   <= sat_ff;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
      end else if (do_op && ctrl.cw.op == OP_INTEG_SAT) begin
         integ_ff <= sat32(sum_ff);
      end else if (do_op && ctrl.cw.op == OP_PRESET) begin
         integ_ff <= pre_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (do_op && ctrl.cw.op == OP_EMIT) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      status.is_preset = cmd_ff;
      status.out_free  = !out_valid_ff || rsp_ready;
      rsp_valid        = out_valid_ff;
      rsp_drive        = out_drive_ff;
      rsp_sat          = out_sat_ff;
   end

endmodule

// File: sv/pic_checker.sv
// port-level assertions for the pi controller, bound to the top level
`timescale 1ns / 1ps

module pic_checker
   import pic_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic [0:0]       req_tuser,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [SIG_W-1:0] rsp_tdata,
   input logic [0:0]       rsp_tuser
);

   a_reset_clean: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("block not idle and empty after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("new item taken while one is in progress");

   a_preset_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[0] |=>
         !$rose(rsp_tvalid) ##1 !$rose(rsp_tvalid))
      else $error("preset item produced a result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed or dropped");

endmodule

bind pi_controller_backcalc_antiwindup pic_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: tb/pi_controller_backcalc_antiwindup_test.sv
// self-checking testbench for the pi controller: directed table, then random retuned phases
`timescale 1ns / 1ps

module pi_controller_backcalc_antiwindup_test;
   import pic_pkg::*;

   localparam int          CLOCK_PERIOD = 12;
   localparam int          GAIN_FRAC    = 16;
   localparam int          DRAIN_CYCLES = 20;
   localparam int          RANDOM_ITEMS = 1500;
   localparam int unsigned CYCLE_LIMIT  = 500000;

   localparam logic CMD_STEP   = 1'b0;
   localparam logic CMD_PRESET = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 3'd7;

   localparam logic [SIG_W-1:0]  TOP_SIG       = 32'h7FFF_FFFF;
   localparam logic [SIG_W-1:0]  BOTTOM_SIG    = 32'h8000_0000;
   localparam logic [SIG_W-1:0]  ONE_SIG       = 32'h0001_0000;
   localparam logic [SIG_W-1:0]  MINUS_ONE_SIG = 32'hFFFF_0000;
   localparam logic [GAIN_W-1:0] GAIN_TOP      = 24'h7F_FFFF;
   localparam logic [GAIN_W-1:0] GAIN_BOTTOM   = 24'h80_0000;
   localparam longint            SAT_HIGH      = 64'sh7FFF_FFFF;
   localparam longint            SAT_LOW       = -64'sh8000_0000;

   typedef struct packed {
      logic [SIG_W-1:0] drive;
      logic             sat;
   } drive_result_type;

   typedef enum logic [1:0] {
      ROW_WRITE,
      ROW_STEP,
      ROW_PRESET
   } row_kind_type;

   typedef struct packed {
      row_kind_type     kind;
      logic [SIG_W-1:0] a;      // error, preset value or register index
      logic [SIG_W-1:0] b;      // feedforward or register data
      logic             typed;  // expected result given in the row
      logic [SIG_W-1:0] drive;
      logic             sat;
   } plan_row_type;

   localparam int PLAN_LEN = 38;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;  // error_value, feedforward_value, preset_value
   logic [0:0]            req_tuser;  // command
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [SIG_W-1:0]      rsp_tdata;  // drive_value
   logic [0:0]            rsp_tuser;  // saturated
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [SIG_W-1:0]      csr_data;

   logic signed [GAIN_W-1:0] kp_q;
   logic signed [GAIN_W-1:0] ki_q;
   logic [PERIOD_W-1:0]      ts_q;
   logic signed [GAIN_W-1:0] kaw_q;
   logic signed [SIG_W-1:0]  lower_q;
   logic signed [SIG_W-1:0]  upper_q;
   longint                   integ_q;

   drive_result_type drive_expect_q[$];

   logic        quiet = 1'b0;
   int unsigned cycle_count = 0;
   int          fail_count = 0;
   int          steps_sent = 0;
   int          presets_sent = 0;
   int          writes_done = 0;
   int          results_seen = 0;
   int          saturated_seen = 0;

   plan_row_type plan [PLAN_LEN] = '{
      '{ROW_STEP,   TOP_SIG,    32'h0,         1'b1, 32'h0,         1'b0},
      '{ROW_STEP,   BOTTOM_SIG, TOP_SIG,       1'b1, TOP_SIG,       1'b0},
      '{ROW_STEP,   32'h0,      BOTTOM_SIG,    1'b1, BOTTOM_SIG,    1'b0},
      '{ROW_PRESET, TOP_SIG,    32'h0,         1'b0, 32'h0,         1'b0},
      '{ROW_STEP,   32'h0,      TOP_SIG,       1'b1, TOP_SIG,       1'b0},
      '{ROW_STEP,   32'h0,      BOTTOM_SIG,    1'b1, 32'hFFFF_FFFF, 1'b0},
      '{ROW_PRESET, BOTTOM_SIG, 32'h0,         1'b0, 32'h0,         1'b0},
      '{ROW_STEP,   32'h0,      BOTTOM_SIG,    1'b1, BOTTOM_SIG,    1'b0},
      '{ROW_WRITE,  SIG_W'(REG_SPARE), 32'h1234_5678, 1'b0, 32'h0,  1'b0},
      '{ROW_STEP,   32'h0,      32'h0,         1'b1, BOTTOM_SIG,    1'b0},
      '{ROW_WRITE,  SIG_W'(REG_LO), ONE_SIG,       1'b0, 32'h0,     1'b0},
      '{ROW_WRITE,  SIG_W'(REG_HI), MINUS_ONE_SIG, 1'b0, 32'h0,     1'b0},
      '{ROW_PRESET, 32'h0,      32'h0,         1'b0, 32'h0,         1'b0},
      '{ROW_STEP,   32'h0,      32'h0002_0000, 1'b1, MINUS_ONE_SIG, 1'b1},
      '{ROW_STEP,   32'h0,      32'h0,         1'b1, ONE_SIG,       1'b1},
      '{ROW_STEP,   32'h0,      ONE_SIG,       1'b1, MINUS_ONE_SIG, 1'b1},
      '{ROW_WRITE,  SIG_W'(REG_KP),  GAIN_TOP,      1'b0, 32'h0,    1'b0},
      '{ROW_WRITE,  SIG_W'(REG_KI),  GAIN_TOP,      1'b0, 32'h0,    1'b0},
      '{ROW_WRITE,  SIG_W'(REG_TS),  32'hFF_FFFF,   1'b0, 32'h0,    1'b0},
      '{ROW_WRITE,  SIG_W'(REG_KAW), GAIN_BOTTOM,   1'b0, 32'h0,    1'b0},
      '{ROW_WRITE,  SIG_W'(REG_LO),  MINUS_ONE_SIG, 1'b0, 32'h0,    1'b0},
      '{ROW_WRITE,  SIG_W'(REG_HI),  ONE_SIG,       1'b0, 32'h0,    1'b0},
      '{ROW_PRESET, 32'h0,      32'h0,         1'b0, 32'h0,         1'b0},
      '{ROW_STEP,   TOP_SIG,    32'h0,         1'b1, ONE_SIG,       1'b1},
      '{ROW_STEP,   BOTTOM_SIG, 32'h0,         1'b0, 32'h0,         1'b0},
      '{ROW_STEP,   32'h1,      32'h0,         1'b0, 32'h0,         1'b0},
      '{ROW_STEP,   32'hFFFF_FFFF, ONE_SIG,    1'b0, 32'h0,         1'b0},
      '{ROW_WRITE,  SIG_W'(REG_KP),  GAIN_BOTTOM,   1'b0, 32'h0,    1'b0},
      '{ROW_WRITE,  SIG_W'(REG_KI),  GAIN_BOTTOM,   1'b0, 32'h0,    1'b0},
      '{ROW_WRITE,  SIG_W'(REG_TS),  32'h1,         1'b0, 32'h0,    1'b0},
      '{ROW_WRITE,  SIG_W'(REG_KAW), GAIN_TOP,      1'b0, 32'h0,    1'b0},
      '{ROW_WRITE,  SIG_W'(REG_LO),  BOTTOM_SIG,    1'b0, 32'h0,    1'b0},
      '{ROW_WRITE,  SIG_W'(REG_HI),  TOP_SIG,       1'b0, 32'h0,    1'b0},
      '{ROW_STEP,   TOP_SIG,    32'h0,         1'b0, 32'h0,         1'b0},
      '{ROW_STEP,   BOTTOM_SIG, TOP_SIG,       1'b0, 32'h0,         1'b0},
      '{ROW_PRESET, 32'h0000_8000, 32'h0,      1'b0, 32'h0,         1'b0},
      '{ROW_STEP,   32'h1,      BOTTOM_SIG,    1'b0, 32'h0,         1'b0},
      '{ROW_STEP,   32'hFFFF_FFFF, 32'h0,      1'b0, 32'h0,         1'b0}
   };

   pi_controller_backcalc_antiwindup #(
      .GAIN_FRACTION_BITS(GAIN_FRAC)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic longint round_shift(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic longint clip32(longint v);
      if (v > SAT_HIGH) begin
         return SAT_HIGH;
      end
      if (v < SAT_LOW) begin
         return SAT_LOW;
      end
      return v;
   endfunction

   function automatic drive_result_type predict_drive(logic signed [SIG_W-1:0] err,
                                                      logic signed [SIG_W-1:0] ff);
      longint           e;
      longint           p;
      longint           raw;
      longint           held;
      longint           kits;
      longint           inc_i;
      longint           inc_aw;
      drive_result_type r;
      e = longint'(err);
      p = clip32(round_shift(longint'(kp_q) * e, GAIN_FRAC));
      raw = clip32(clip32(p + integ_q) + longint'(ff));
      held = raw;
      r.sat = 1'b0;
      // crossed limits: the lower bound wins
      if (raw < longint'(lower_q)) begin
         held = longint'(lower_q);
         r.sat = 1'b1;
      end else if (raw > longint'(upper_q)) begin
         held = longint'(upper_q);
         r.sat = 1'b1;
      end
      kits = round_shift(longint'(ki_q) * longint'({1'b0, ts_q}), PERIOD_FRAC);
      inc_i = round_shift(kits * e, GAIN_FRAC);
      inc_aw = round_shift(longint'(kaw_q) * (held - raw), GAIN_FRAC);
      integ_q = clip32(integ_q + inc_i + inc_aw);
      r.drive = held[SIG_W-1:0];
      return r;
   endfunction

   function automatic logic [SIG_W-1:0] spread(int unsigned half);
      return int'($urandom_range(0, 2 * half)) - int'(half);
   endfunction

   function automatic logic [SIG_W-1:0] pick_signal(int unsigned half);
      case ($urandom_range(0, 15))
         0: return TOP_SIG;
         1: return BOTTOM_SIG;
         2: return '0;
         3, 4: return $urandom();
         default: return spread(half);
      endcase
   endfunction

   function automatic logic [SIG_W-1:0] pick_gain(int mode, int unsigned half);
      case (mode)
         0: begin
            case ($urandom_range(0, 2))
               0: return {8'h00, GAIN_TOP};
               1: return {8'hFF, GAIN_BOTTOM};
               default: return '0;
            endcase
         end
         1: return $urandom();
         default: return spread(half);
      endcase
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [SIG_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_KP:  kp_q = val[GAIN_W-1:0];
         REG_KI:  ki_q = val[GAIN_W-1:0];
         REG_TS:  ts_q = val[PERIOD_W-1:0];
         REG_KAW: kaw_q = val[GAIN_W-1:0];
         REG_LO:  lower_q = val;
         REG_HI:  upper_q = val;
         default: ;
      endcase
      writes_done++;
   endtask

   task automatic send_item(logic cmd, logic [SIG_W-1:0] err, logic [SIG_W-1:0] ff,
                            logic [SIG_W-1:0] pre, logic typed, drive_result_type typed_val);
      int               gap;
      drive_result_type r;
      gap = quiet ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {pre, ff, err};
      do @(posedge clock); while (!req_tready);
      if (cmd == CMD_PRESET) begin
         integ_q = longint'($signed(pre));
         presets_sent++;
      end else begin
         r = predict_drive(err, ff);
         drive_expect_q.push_back(typed ? typed_val : r);
         steps_sent++;
      end
   endtask

   // wait for every result, then let a preset still in flight finish
   task automatic settle();
      req_tvalid <= 1'b0;
      while (drive_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic retune();
      int               mode;
      logic [SIG_W-1:0] a;
      logic [SIG_W-1:0] b;
      logic [SIG_W-1:0] lo;
      logic [SIG_W-1:0] hi;
      settle();
      mode = $urandom_range(0, 5);
      if ($urandom_range(0, 2) != 0) write_reg(REG_KP, pick_gain(mode, 32'h4_0000));
      if ($urandom_range(0, 2) != 0) write_reg(REG_KI, pick_gain(mode, 32'h40_0000));
      if ($urandom_range(0, 2) != 0) begin
         case (mode)
            0: write_reg(REG_TS, ($urandom_range(0, 1) != 0) ? 32'hFF_FFFF : 32'h0);
            1: write_reg(REG_TS, $urandom());
            default: write_reg(REG_TS, $urandom_range(1, 32'h10_0000));
         endcase
      end
      if ($urandom_range(0, 2) != 0) write_reg(REG_KAW, pick_gain(mode, 32'h2_0000));
      case ($urandom_range(0, 5))
         0: begin
            lo = BOTTOM_SIG;
            hi = TOP_SIG;
         end
         1: begin
            a = spread(32'h200_0000);
            b = spread(32'h200_0000);
            lo = ($signed(a) > $signed(b)) ? a : b;
            hi = ($signed(a) > $signed(b)) ? b : a;
         end
         2: begin
            lo = spread(32'h100_0000);
            hi = lo;
         end
         3: begin
            lo = $urandom();
            hi = $urandom();
         end
         default: begin
            a = $urandom_range(32'h100, 32'h400_0000);
            lo = -a;
            hi = a;
         end
      endcase
      if ($urandom_range(0, 3) != 0) begin
         write_reg(REG_LO, lo);
         write_reg(REG_HI, hi);
      end
      if ($urandom_range(0, 9) == 0) write_reg(CSR_IDX_W'($urandom_range(6, 7)), $urandom());
      csr_valid <= 1'b0;
   endtask

   // result side
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 9);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && !reset));
      end
   end

   always @(posedge clock) begin
      drive_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (rsp_tuser[0]) saturated_seen++;
         if (drive_expect_q.size() == 0) begin
            if (fail_count < 10) begin
               $display("unexpected result: drive %h sat %b", rsp_tdata, rsp_tuser[0]);
            end
            fail_count++;
         end else begin
            want = drive_expect_q.pop_front();
            if (rsp_tdata !== want.drive || rsp_tuser[0] !== want.sat) begin
               if (fail_count < 10) begin
                  $display("result %0d mismatch: expected drive %h sat %b, got drive %h sat %b",
                           results_seen, want.drive, want.sat, rsp_tdata, rsp_tuser[0]);
               end
               fail_count++;
            end
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timed out after %0d cycles", cycle_count);
      $display("pi_controller_backcalc_antiwindup_test: FAIL");
      $finish;
   end

   initial begin
      plan_row_type row;
      int           target;
      int           burst;
      int unsigned  err_half;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_data   <= '0;
      kp_q    = '0;
      ki_q    = '0;
      ts_q    = '0;
      kaw_q   = '0;
      lower_q = BOTTOM_SIG;
      upper_q = TOP_SIG;
      integ_q = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < PLAN_LEN; i++) begin
         row = plan[i];
         case (row.kind)
            ROW_WRITE: begin
               if (i == 0 || plan[i-1].kind != ROW_WRITE) settle();
               write_reg(row.a[CSR_IDX_W-1:0], row.b);
               if (i == PLAN_LEN - 1 || plan[i+1].kind != ROW_WRITE) csr_valid <= 1'b0;
            end
            ROW_STEP: send_item(CMD_STEP, row.a, row.b, '0, row.typed, {row.drive, row.sat});
            default: send_item(CMD_PRESET, '0, '0, row.a, 1'b0, '0);
         endcase
      end

      target = steps_sent + presets_sent + RANDOM_ITEMS;
      while (steps_sent + presets_sent < target) begin
         retune();
         quiet = ($urandom_range(0, 4) == 0);
         err_half = $urandom_range(32'h8000, 32'h100_0000);
         burst = $urandom_range(30, 120);
         for (int n = 0; n < burst; n++) begin
            if ($urandom_range(0, 63) == 0) settle();
            if ($urandom_range(0, 9) == 0) begin
               send_item(CMD_PRESET, $urandom(), $urandom(), pick_signal(err_half * 4),
                         1'b0, '0);
            end else begin
               send_item(CMD_STEP, pick_signal(err_half), pick_signal(err_half), $urandom(),
                         1'b0, '0);
            end
         end
      end
      quiet = 1'b0;

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (drive_expect_q.size() != 0) begin
         $display("%0d expected results never arrived", drive_expect_q.size());
         fail_count += drive_expect_q.size();
      end
      $display("covered %0d control steps and %0d integrator presets across %0d register writes",
               steps_sent, presets_sent, writes_done);
      $display("checked %0d drive results, %0d of them clamped at a limit",
               results_seen, saturated_seen);
      if (fail_count == 0) begin
         $display("pi_controller_backcalc_antiwindup_test: PASS");
      end else begin
         $display("pi_controller_backcalc_antiwindup_test: FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/pic_pkg.sv
sv/pic_ucode_rom.sv
sv/pic_sequencer.sv
sv/pic_datapath.sv
sv/pi_controller_backcalc_antiwindup.sv
sv/pic_checker.sv
tb/pi_controller_backcalc_antiwindup_test.sv
